[src/isf_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the independent set filter.
package isf_pkg;

  localparam int ROW_W           = 20;
  localparam int VCOUNT_W        = 5;
  localparam int SET_SIZE_W      = 3;
  localparam int KEPT_W          = 16;
  localparam int MIN_SET_SIZE    = 3;
  localparam int DEF_MAX_VERTICES = 20;
  localparam int DEF_MAX_SET_SIZE = 6;
  localparam logic [KEPT_W-1:0] KEPT_MAX = '1;
  localparam logic [SET_SIZE_W-1:0] SET_SIZE_RESET = SET_SIZE_W'(MIN_SET_SIZE);

  typedef struct packed {
    logic [ROW_W-1:0]    row_bits;
    logic [VCOUNT_W-1:0] vertex_count;
    logic                last_row;
  } isf_in_t;

  typedef struct packed {
    logic              set_found;
    logic [KEPT_W-1:0] kept_count;
  } isf_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EMIT
  } isf_state_t;

  typedef struct packed {
    logic load;
    logic start;
    logic step;
    logic emit;
  } isf_cmd_t;

  typedef struct packed {
    logic step_done;
    logic slot_free;
  } isf_sts_t;

endpackage

[src/isf_ctrl.sv]
`timescale 1ns / 1ps
// Controller state machine: row loading, search stepping and result hand-off.
module isf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_stall,
  input  isf_pkg::isf_sts_t sts,
  output isf_pkg::isf_cmd_t cmd
);
  import isf_pkg::*;

  isf_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) begin
            cmd.start = 1'b1;
            state_nxt = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        cmd.step = 1'b1;
        if (sts.step_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.slot_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[src/isf_dp.sv]
`timescale 1ns / 1ps
// Datapath: adjacency store, backtracking search stack, kept counter, result register.
module isf_dp #(
  parameter int MAX_VERTICES = isf_pkg::DEF_MAX_VERTICES,
  parameter int MAX_SET_SIZE = isf_pkg::DEF_MAX_SET_SIZE
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  isf_pkg::isf_in_t                 in_data,
  input  logic                             cfg_wr,
  input  logic [isf_pkg::SET_SIZE_W-1:0]   cfg_data,
  input  isf_pkg::isf_cmd_t                cmd,
  output isf_pkg::isf_sts_t                sts,
  output logic                             out_valid,
  input  logic                             out_stall,
  output isf_pkg::isf_out_t                out_data
);
  import isf_pkg::*;

  localparam int IDX_W   = $clog2(MAX_VERTICES);
  localparam int CNT_W   = $clog2(MAX_VERTICES + 1);
  localparam int DEPTH_W = $clog2(MAX_SET_SIZE);
  localparam int SET_W   = $clog2(MAX_SET_SIZE + 1);
  localparam int NCMP_W  = (CNT_W > VCOUNT_W) ? CNT_W : VCOUNT_W;
  localparam int KCMP_W  = (SET_W > SET_SIZE_W) ? SET_W : SET_SIZE_W;

  logic [ROW_W-1:0]        store_r [MAX_VERTICES];
  logic [CNT_W-1:0]        row_idx_r, row_idx_nxt;
  logic [MAX_VERTICES-1:0] cand_r [MAX_SET_SIZE];
  logic [DEPTH_W-1:0]      depth_r;
  logic [SET_SIZE_W-1:0]   set_size_r;
  logic                    found_r;
  logic [KEPT_W-1:0]       kept_r, kept_nxt;
  logic                    out_valid_r, out_valid_nxt;
  isf_out_t                out_data_r;

  logic [NCMP_W-1:0]       n_ext;
  logic [MAX_VERTICES-1:0] all_mask;
  logic [KCMP_W-1:0]       k_ext;
  logic [SET_W-1:0]        k_val;
  logic [MAX_VERTICES-1:0] cur, cur_clr, row_ext, next_cand;
  logic [IDX_W-1:0]        pick;
  logic [ROW_W-1:0]        pick_row;
  logic                    cur_empty, depth_last, row_room;

  // clamp vertex count and form the initial candidate set
  always_comb begin
    n_ext = NCMP_W'(in_data.vertex_count);
    if (n_ext > NCMP_W'(MAX_VERTICES)) begin
      n_ext = NCMP_W'(MAX_VERTICES);
    end
    for (int i = 0; i < MAX_VERTICES; i++) begin
      all_mask[i] = (NCMP_W'(i) < n_ext);
    end
  end

  // clamp set size
  always_comb begin
    k_ext = KCMP_W'(set_size_r);
    if (k_ext < KCMP_W'(MIN_SET_SIZE)) begin
      k_ext = KCMP_W'(MIN_SET_SIZE);
    end else if (k_ext > KCMP_W'(MAX_SET_SIZE)) begin
      k_ext = KCMP_W'(MAX_SET_SIZE);
    end
    k_val = SET_W'(k_ext);
  end

  // one search step: take lowest candidate, narrow by its non-neighbours above
  always_comb begin
    cur       = cand_r[depth_r];
    cur_empty = (cur == '0);
    pick      = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (cur[i]) begin
        pick = IDX_W'(i);
      end
    end
    cur_clr       = cur;
    cur_clr[pick] = 1'b0;
    pick_row      = store_r[pick];
    row_ext       = '0;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      if (i < ROW_W) begin
        row_ext[i] = pick_row[i];
      end
    end
    next_cand  = cur_clr & ~row_ext;
    depth_last = ((SET_W'(depth_r) + SET_W'(1)) == k_val);
  end

  assign row_room      = (row_idx_r < CNT_W'(MAX_VERTICES));
  assign sts.step_done = cur_empty ? (depth_r == '0) : depth_last;
  assign sts.slot_free = !out_valid_r || !out_stall;

  always_comb begin
    row_idx_nxt = row_idx_r;
    if (cmd.load) begin
      if (in_data.last_row) begin
        row_idx_nxt = '0;
      end else if (row_room) begin
        row_idx_nxt = row_idx_r + CNT_W'(1);
      end
    end
  end

  always_comb begin
    kept_nxt = kept_r;
    if (!found_r && kept_r != KEPT_MAX) begin
      kept_nxt = kept_r + KEPT_W'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && row_room) begin
      store_r[row_idx_r[IDX_W-1:0]] <= in_data.row_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cand_r[0] <= all_mask;
    end else if (cmd.step && !cur_empty) begin
      cand_r[depth_r] <= cur_clr;
      if (!depth_last) begin
        cand_r[DEPTH_W'(depth_r + DEPTH_W'(1))] <= next_cand;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && sts.step_done) begin
      found_r <= !cur_empty;
    end
    if (cmd.emit) begin
      out_data_r.set_found  <= found_r;
      out_data_r.kept_count <= kept_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_idx_r   <= '0;
      depth_r     <= '0;
      set_size_r  <= SET_SIZE_RESET;
      kept_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      row_idx_r   <= row_idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        set_size_r <= cfg_data;
      end
      if (cmd.emit) begin
        kept_r <= kept_nxt;
      end
      if (cmd.start) begin
        depth_r <= '0;
      end else if (cmd.step) begin
        if (cur_empty) begin
          if (depth_r != '0) begin
            depth_r <= depth_r - DEPTH_W'(1);
          end
        end else if (!depth_last) begin
          depth_r <= depth_r + DEPTH_W'(1);
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[src/independent_set_filter.sv]
`timescale 1ns / 1ps
// Top level: row beats are taken while the controller is idle; the last row starts the subset search.
// Search: each backtracking step tries one candidate vertex or pops one level; after
// the search the emit state writes the result register once the output slot is free.
// Input is stalled from the last row until the result is emitted, so a new graph waits
// for the previous one to finish; the step count is data dependent.
// Reset: rst_n clears row index, set size (to 3), kept count and all handshake state;
// adjacency rows hold no reset value and are defined once written.
module independent_set_filter #(
  parameter int MAX_VERTICES = isf_pkg::DEF_MAX_VERTICES,
  parameter int MAX_SET_SIZE = isf_pkg::DEF_MAX_SET_SIZE
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  isf_pkg::isf_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output isf_pkg::isf_out_t              out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [isf_pkg::SET_SIZE_W-1:0] cfg_data
);
  import isf_pkg::*;

  isf_cmd_t cmd;
  isf_sts_t sts;

  assign cfg_ready = 1'b1;

  isf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.last_row),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  isf_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_SET_SIZE (MAX_SET_SIZE)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
